[src/nks_pkg.sv]
// Package for the nearest-K point selector: widths, register codes and the
// candidate record that passes from the distance front end to the sorter.
// No dependencies; every other file of the block imports it.
package nks_pkg;

  localparam int K_NEAREST      = 6;
  localparam int INDEX_WIDTH    = 10;
  localparam int COORD_WIDTH    = 16;
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int DIST_WIDTH     = 2 * COORD_WIDTH + 2;
  localparam int RANK_WIDTH     = 3;
  localparam int SEL_WIDTH      = (K_NEAREST > 1) ? $clog2(K_NEAREST) : 1;
  localparam int CFG_ADDR_WIDTH = 2;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1,
    REG_REF_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] point_index;
    logic [DIST_WIDTH-1:0]  sq_dist;
    logic                   final_point;
  } cand_t;

endpackage

[src/nks_if.sv]
// Channel interfaces of the nearest-K point selector: candidate input,
// ranked result output and configuration write port. Depends on nks_pkg.
interface nks_in_if import nks_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [INDEX_WIDTH-1:0]        point_index;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          final_point;

  modport source(output valid, point_index, pos_x, pos_y, pos_z, final_point, input ready);
  modport sink(input valid, point_index, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

interface nks_out_if import nks_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RANK_WIDTH-1:0]  rank;
  logic [INDEX_WIDTH-1:0] chosen_index;
  logic [DIST_WIDTH-1:0]  squared_distance;
  logic                   found;
  logic                   last_of_run;

  modport source(output valid, rank, chosen_index, squared_distance, found, last_of_run,
                 input ready);
  modport sink(input valid, rank, chosen_index, squared_distance, found, last_of_run,
               output ready);
endinterface

interface nks_cfg_if import nks_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CFG_ADDR_WIDTH-1:0]     addr;
  logic signed [COORD_WIDTH-1:0] data;

  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

[src/nks_front.sv]
// Front end: reference registers and a three-stage squared-distance pipeline
// (difference, square, sum) that hands candidates to the queue. Uses nks_pkg.
module nks_front import nks_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  nks_cfg_if.sink    cfg,
  nks_in_if.sink     in_s,
  output logic       cand_valid,
  input  logic       cand_ready,
  output cand_t      cand
);

  logic signed [COORD_WIDTH-1:0] ref_x_r, ref_y_r, ref_z_r;

  logic                         s1_valid_r;
  logic signed [DIFF_WIDTH-1:0] dx_r, dy_r, dz_r;
  logic [INDEX_WIDTH-1:0]       s1_index_r;
  logic                         s1_final_r;

  logic                         s2_valid_r;
  logic [DIST_WIDTH-1:0]        sqx_r, sqy_r, sqz_r;
  logic [INDEX_WIDTH-1:0]       s2_index_r;
  logic                         s2_final_r;

  logic                         s3_valid_r;
  cand_t                        s3_cand_r;

  logic                         adv;
  logic signed [DIFF_WIDTH-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [DIST_WIDTH-1:0] sqx, sqy, sqz;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      ref_z_r <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.addr))
        REG_REF_X: ref_x_r <= cfg.data;
        REG_REF_Y: ref_y_r <= cfg.data;
        REG_REF_Z: ref_z_r <= cfg.data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; it holds only when the last stage
  // cannot hand its candidate to the queue.
  assign adv       = !s3_valid_r || cand_ready;
  assign in_s.ready = adv;

  assign dx_nxt = DIFF_WIDTH'(in_s.pos_x) - DIFF_WIDTH'(ref_x_r);
  assign dy_nxt = DIFF_WIDTH'(in_s.pos_y) - DIFF_WIDTH'(ref_y_r);
  assign dz_nxt = DIFF_WIDTH'(in_s.pos_z) - DIFF_WIDTH'(ref_z_r);

  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sqz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_s.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      dz_r       <= dz_nxt;
      s1_index_r <= in_s.point_index;
      s1_final_r <= in_s.final_point;

      sqx_r      <= $unsigned(sqx);
      sqy_r      <= $unsigned(sqy);
      sqz_r      <= $unsigned(sqz);
      s2_index_r <= s1_index_r;
      s2_final_r <= s1_final_r;

      s3_cand_r.point_index <= s2_index_r;
      s3_cand_r.sq_dist     <= sqx_r + sqy_r + sqz_r;
      s3_cand_r.final_point <= s2_final_r;
    end
  end

  assign cand_valid = s3_valid_r;
  assign cand       = s3_cand_r;

endmodule

[src/nks_fifo.sv]
// Short candidate queue between the distance front end and the sorter, so
// that each side can stall on its own. Uses cand_t from nks_pkg.
module nks_fifo import nks_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  cand_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cand_t pop_data
);

  cand_t                     mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_WIDTH-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_WIDTH:0]   count_r;
  logic                      do_push, do_pop;

  assign push_ready = (count_r != (FIFO_PTR_WIDTH+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[src/nks_back.sv]
// Back end: sorted store of the K nearest candidates with parallel
// insertion, a snapshot buffer for a finished set and the registered result
// output that walks the ranks. Uses nks_pkg and the result interface.
module nks_back import nks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cand_valid,
  output logic      cand_ready,
  input  cand_t     cand,
  nks_out_if.source out_s
);

  logic [K_NEAREST-1:0]   kv_r;
  logic [DIST_WIDTH-1:0]  kd_r [K_NEAREST];
  logic [INDEX_WIDTH-1:0] ki_r [K_NEAREST];

  logic [K_NEAREST-1:0]   sv_r;
  logic [DIST_WIDTH-1:0]  sd_r [K_NEAREST];
  logic [INDEX_WIDTH-1:0] si_r [K_NEAREST];

  logic                   emit_busy_r;
  logic [SEL_WIDTH-1:0]   emit_cnt_r;

  logic                   out_valid_r;
  logic [RANK_WIDTH-1:0]  out_rank_r;
  logic [INDEX_WIDTH-1:0] out_index_r;
  logic [DIST_WIDTH-1:0]  out_dist_r;
  logic                   out_found_r;
  logic                   out_last_r;

  logic [K_NEAREST-1:0]   lt, eq, ins_v;
  logic [DIST_WIDTH-1:0]  ins_d [K_NEAREST];
  logic [INDEX_WIDTH-1:0] ins_i [K_NEAREST];
  logic                   any_eq;
  logic                   take, take_final, out_load, emit_done;

  assign cand_ready = !cand.final_point || !emit_busy_r;
  assign take       = cand_valid && cand_ready;
  assign take_final = take && cand.final_point;

  // The valid entries form a strictly increasing prefix, so at most one entry
  // can match the new distance, and it sits at the insertion point.
  always_comb begin
    for (int i = 0; i < K_NEAREST; i++) begin
      lt[i] = kv_r[i] && (kd_r[i] < cand.sq_dist);
      eq[i] = kv_r[i] && (kd_r[i] == cand.sq_dist);
    end
    any_eq = |eq;
    for (int i = 0; i < K_NEAREST; i++) begin
      ins_v[i] = kv_r[i];
      ins_d[i] = kd_r[i];
      ins_i[i] = ki_r[i];
      if (any_eq) begin
        if (eq[i]) begin
          ins_i[i] = cand.point_index;
        end
      end else if (!lt[i]) begin
        if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
          ins_v[i] = 1'b1;
          ins_d[i] = cand.sq_dist;
          ins_i[i] = cand.point_index;
        end else begin
          ins_v[i] = kv_r[(i == 0) ? 0 : i-1];
          ins_d[i] = kd_r[(i == 0) ? 0 : i-1];
          ins_i[i] = ki_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r <= '0;
    end else if (take) begin
      kv_r <= take_final ? '0 : ins_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kd_r <= ins_d;
      ki_r <= ins_i;
    end
    if (take_final) begin
      sd_r <= ins_d;
      si_r <= ins_i;
    end
  end

  assign out_load  = emit_busy_r && (!out_valid_r || out_s.ready);
  assign emit_done = (emit_cnt_r == SEL_WIDTH'(K_NEAREST - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      emit_busy_r <= 1'b0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_final) begin
        sv_r        <= ins_v;
        emit_busy_r <= 1'b1;
        emit_cnt_r  <= '0;
      end else if (out_load) begin
        emit_cnt_r <= emit_done ? '0 : emit_cnt_r + 1'b1;
        if (emit_done) begin
          emit_busy_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rank_r  <= RANK_WIDTH'(emit_cnt_r);
      out_found_r <= sv_r[emit_cnt_r];
      out_index_r <= sv_r[emit_cnt_r] ? si_r[emit_cnt_r] : '0;
      out_dist_r  <= sv_r[emit_cnt_r] ? sd_r[emit_cnt_r] : '0;
      out_last_r  <= emit_done;
    end
  end

  assign out_s.valid            = out_valid_r;
  assign out_s.rank             = out_rank_r;
  assign out_s.chosen_index     = out_index_r;
  assign out_s.squared_distance = out_dist_r;
  assign out_s.found            = out_found_r;
  assign out_s.last_of_run      = out_last_r;

  a_store_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, kv_r} + (K_NEAREST+1)'(1)))
    else $error("Valid entries of the store do not form a prefix.");

  a_store_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    take_final |=> (kv_r == '0))
    else $error("Store not emptied after a final transaction.");

  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_rank_r == RANK_WIDTH'(K_NEAREST - 1)))
    else $error("End of run flagged on a rank other than the last.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_busy_r && !out_load) |=> emit_busy_r)
    else $error("Snapshot released before all ranks were sent.");

endmodule

[src/nearest_k_point_selector.sv]
// Top level of the nearest-K point selector. Instantiates nks_front,
// nks_fifo and nks_back; uses nks_pkg and the channel interfaces in nks_if.
//
// Usage:
//   cfg_ch writes the reference point: index 0, 1, 2 set x, y, z (signed,
//   4 fractional bits); other indexes are ignored. Write only while idle.
//   in_ch carries one candidate point per transaction and accepts one per
//   cycle unless the pipeline holds. Its squared distance to the reference
//   is formed in three stages and queued; the sorter inserts one candidate
//   per cycle unless a final one must wait, into a store of the K nearest,
//   keeping distances strictly increasing, a tie replacing the held index.
//   A transaction with final_point set is inserted, then the store is copied
//   to a result buffer and emptied. out_ch then delivers K results, rank 0
//   first, one per cycle while out_ch is ready; empty ranks come with found
//   low and zero fields. Rank 0 enters the result register after the
//   buffer is marked busy. A second final transaction waits at the head of
//   the queue until the previous run's results have all left the buffer;
//   candidates behind it wait as well.
//   When out_ch stalls, the result register holds, the buffer waits, and a
//   waiting final transaction backs up the four-entry queue, pipeline, in_ch.
//   Reset clears the reference to zero, empties the store, queue and output.
module nearest_k_point_selector import nks_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  nks_cfg_if.sink    cfg_ch,
  nks_in_if.sink     in_ch,
  nks_out_if.source  out_ch
);

  logic  push_valid, push_ready;
  cand_t push_data;
  logic  pop_valid, pop_ready;
  cand_t pop_data;

  nks_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_ch),
    .in_s       (in_ch),
    .cand_valid (push_valid),
    .cand_ready (push_ready),
    .cand       (push_data)
  );

  nks_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nks_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (pop_valid),
    .cand_ready (pop_ready),
    .cand       (pop_data),
    .out_s      (out_ch)
  );

endmodule

[sim/nearest_k_point_selector_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for nearest_k_point_selector: random point sets against an
// in-bench K-nearest predictor, with random idle gaps and a long result stall.
// Depends on nks_pkg, the channel interfaces in nks_if and the block's top level.
module nearest_k_point_selector_tb;
  import nks_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [RANK_WIDTH-1:0]  rank;
    logic [INDEX_WIDTH-1:0] chosen_index;
    logic [DIST_WIDTH-1:0]  squared_distance;
    logic                   found;
    logic                   last_of_run;
  } ranked_t;

  logic clk;
  logic rst_n;

  nks_cfg_if cfg_if();
  nks_in_if  in_if();
  nks_out_if out_if();

  nearest_k_point_selector u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic signed [COORD_WIDTH-1:0] ref_pos_x, ref_pos_y, ref_pos_z;
  logic [DIST_WIDTH-1:0]  near_dist [K_NEAREST];
  logic [INDEX_WIDTH-1:0] near_idx  [K_NEAREST];
  logic                   near_valid[K_NEAREST];
  ranked_t pending_ranks[$];

  int  cycle_count     = 0;
  int  error_count     = 0;
  int  points_sent     = 0;
  int  sets_sent       = 0;
  int  results_checked = 0;
  int  ref_settings    = 0;
  int  hold_request    = 0;
  bit  source_idle_on  = 1;
  bit  sink_idle_on    = 1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_ranks.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] random_offset();
    int span;
    span = ($urandom_range(0, 2) == 0) ? 3 : (($urandom_range(0, 1) == 0) ? 64 : 2000);
    return COORD_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [DIST_WIDTH-1:0] squared_gap(
      input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return DIST_WIDTH'(d * d);
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < K_NEAREST; i++) begin
      near_dist[i]  = '0;
      near_idx[i]   = '0;
      near_valid[i] = 1'b0;
    end
  endfunction

  function automatic void keep_nearest(input logic [INDEX_WIDTH-1:0] idx,
                                       input logic [DIST_WIDTH-1:0] sq_dist);
    int slot;
    slot = 0;
    while (slot < K_NEAREST && near_valid[slot] && near_dist[slot] < sq_dist) slot++;
    if (slot >= K_NEAREST) return;
    if (near_valid[slot] && near_dist[slot] == sq_dist) begin
      near_idx[slot] = idx;
      return;
    end
    for (int i = K_NEAREST - 1; i > slot; i--) begin
      near_dist[i]  = near_dist[i-1];
      near_idx[i]   = near_idx[i-1];
      near_valid[i] = near_valid[i-1];
    end
    near_dist[slot]  = sq_dist;
    near_idx[slot]   = idx;
    near_valid[slot] = 1'b1;
  endfunction

  function automatic void note_point(input logic [INDEX_WIDTH-1:0] idx,
                                     input logic signed [COORD_WIDTH-1:0] x,
                                     input logic signed [COORD_WIDTH-1:0] y,
                                     input logic signed [COORD_WIDTH-1:0] z,
                                     input logic fin);
    ranked_t r;
    keep_nearest(idx, squared_gap(x, ref_pos_x) + squared_gap(y, ref_pos_y)
                      + squared_gap(z, ref_pos_z));
    if (!fin) return;
    for (int k = 0; k < K_NEAREST; k++) begin
      r.rank             = RANK_WIDTH'(k);
      r.chosen_index     = near_valid[k] ? near_idx[k] : '0;
      r.squared_distance = near_valid[k] ? near_dist[k] : '0;
      r.found            = near_valid[k];
      r.last_of_run      = (k == K_NEAREST - 1);
      pending_ranks = {pending_ranks, r};
    end
    clear_store();
  endfunction

  always @(posedge clk) begin : result_check
    ranked_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (pending_ranks.size() == 0) begin
        report_mismatch($sformatf("unexpected result, rank %0d index %0d", out_if.rank,
                                  out_if.chosen_index));
      end else begin
        want = pending_ranks.pop_front();
        if (out_if.rank !== want.rank)
          report_mismatch($sformatf("rank %0d, expected %0d", out_if.rank, want.rank));
        if (out_if.chosen_index !== want.chosen_index)
          report_mismatch($sformatf("rank %0d chosen_index %0d, expected %0d", want.rank,
                                    out_if.chosen_index, want.chosen_index));
        if (out_if.squared_distance !== want.squared_distance)
          report_mismatch($sformatf("rank %0d squared_distance %0d, expected %0d", want.rank,
                                    out_if.squared_distance, want.squared_distance));
        if (out_if.found !== want.found)
          report_mismatch($sformatf("rank %0d found %0b, expected %0b", want.rank,
                                    out_if.found, want.found));
        if (out_if.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("rank %0d last_of_run %0b, expected %0b", want.rank,
                                    out_if.last_of_run, want.last_of_run));
      end
    end
  end

  initial begin : result_sink
    int held;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        out_if.ready <= 1'b0;
        while (held > 0) begin
          @(posedge clk);
          held--;
        end
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_point(input logic [INDEX_WIDTH-1:0] idx,
                            input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y,
                            input logic signed [COORD_WIDTH-1:0] z,
                            input logic fin);
    int gap;
    gap = (source_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.point_index <= idx;
    in_if.pos_x       <= x;
    in_if.pos_y       <= y;
    in_if.pos_z       <= z;
    in_if.final_point <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    note_point(idx, x, y, z, fin);
    points_sent++;
    if (fin) sets_sent++;
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_ranks.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                           input logic signed [COORD_WIDTH-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= addr;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (addr)
      REG_REF_X: ref_pos_x = value;
      REG_REF_Y: ref_pos_y = value;
      REG_REF_Z: ref_pos_z = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_reference(input logic signed [COORD_WIDTH-1:0] x,
                               input logic signed [COORD_WIDTH-1:0] y,
                               input logic signed [COORD_WIDTH-1:0] z);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_REF_X, x);
    write_reg(REG_REF_Y, y);
    write_reg(REG_REF_Z, z);
    ref_settings++;
  endtask

  task automatic test_directed();
    send_point(INDEX_MAX, 0, 0, 0, 1'b1);

    send_point(0, 16, 0, 0, 1'b0);
    send_point(1, 0, 16, 0, 1'b0);
    send_point(2, 0, 0, -16, 1'b0);
    send_point(3, 32, 0, 0, 1'b0);
    send_point(4, -1, -1, -1, 1'b1);

    for (int n = 0; n < K_NEAREST; n++)
      send_point(INDEX_WIDTH'(10 + n), COORD_WIDTH'(n + 1), 0, 0, 1'b0);
    send_point(20, 100, 0, 0, 1'b0);
    send_point(21, 0, 0, 0, 1'b1);

    set_reference(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(INDEX_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);

    set_reference(COORD_MAX, COORD_MIN, COORD_MAX);
    write_reg(REG_UNUSED, 16'sh0123);
    send_point(5, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
  endtask

  task automatic test_random_sets();
    logic signed [COORD_WIDTH-1:0] rx, ry, rz, px, py, pz, ox, oy, oz;
    int set_size;
    int phase_points;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          rx = 0; ry = 0; rz = 0;
        end
        1: begin
          rx = COORD_MAX; ry = COORD_MAX; rz = COORD_MAX;
        end
        2: begin
          rx = COORD_MIN; ry = COORD_MIN; rz = COORD_MIN;
        end
        default: begin
          rx = COORD_WIDTH'($urandom); ry = COORD_WIDTH'($urandom);
          rz = COORD_WIDTH'($urandom);
        end
      endcase
      set_reference(rx, ry, rz);
      source_idle_on = (phase != 3);
      sink_idle_on   = (phase != 3);
      phase_points = 0;
      ox = 0; oy = 0; oz = 0;
      while (phase_points < 36) begin
        set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 8);
        for (int n = 0; n < set_size; n++) begin
          case ($urandom_range(0, 3))
            0: begin
              px = COORD_WIDTH'($urandom); py = COORD_WIDTH'($urandom);
              pz = COORD_WIDTH'($urandom);
            end
            1, 2: begin
              ox = random_offset(); oy = random_offset(); oz = random_offset();
              px = rx + ox; py = ry + oy; pz = rz + oz;
            end
            default: begin
              px = rx - oy; py = ry + ox; pz = rz - oz;
            end
          endcase
          send_point(INDEX_WIDTH'($urandom_range(0, INDEX_MAX)), px, py, pz,
                     n == set_size - 1);
        end
        phase_points += set_size;
      end
    end
    source_idle_on = 1;
    sink_idle_on   = 1;
  endtask

  task automatic test_backpressure();
    logic signed [COORD_WIDTH-1:0] rx, ry, rz;
    rx = COORD_WIDTH'($urandom); ry = COORD_WIDTH'($urandom); rz = COORD_WIDTH'($urandom);
    set_reference(rx, ry, rz);
    source_idle_on = 0;
    hold_request = 150;
    for (int n = 0; n < 32; n++)
      send_point(INDEX_WIDTH'($urandom_range(0, INDEX_MAX)), rx + random_offset(),
                 ry + random_offset(), rz + random_offset(), n % 4 == 3);
    wait_for_results();
    source_idle_on = 1;
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.point_index <= '0;
    in_if.pos_x       <= '0;
    in_if.pos_y       <= '0;
    in_if.pos_z       <= '0;
    in_if.final_point <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.addr       <= REG_REF_X;
    cfg_if.data       <= '0;
    rst_n             <= 1'b0;
    ref_pos_x = 0;
    ref_pos_y = 0;
    ref_pos_z = 0;
    clear_store();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_sets();
    test_backpressure();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_ranks.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_ranks.size()));

    $display("Sent %0d points in %0d sets and checked %0d ranked results,", points_sent,
             sets_sent, results_checked);
    $display("over %0d reference settings, with idle gaps and a long result stall.",
             ref_settings);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
